// ===== rtl/smp_pkg.sv =====
package smp_pkg;

    localparam int ELEM_W = 16;
    localparam int ROW_W = 64;
    localparam int ACC_W = 36;
    localparam int FRAC_BITS = 12;
    localparam int DEF_MAX_BONES = 64;
    localparam int ID_W = 6;

    localparam logic [ROW_W-1:0] BIND_RST0 = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] BIND_RST1 = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] BIND_RST2 = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] BIND_RST3 = 64'h1000_0000_0000_0000;

    localparam logic [1:0] REG_BIND0 = 2'd0;
    localparam logic [1:0] REG_BIND1 = 2'd1;
    localparam logic [1:0] REG_BIND2 = 2'd2;
    localparam logic [1:0] REG_BIND3 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WORLD,
        ST_TMP,
        ST_SKIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } cell_ctrl_t;

    function automatic logic [ELEM_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-FRAC_BITS-1:0] q;
        begin
            t = acc + ACC_W'(2048);
            q = t[ACC_W-1:FRAC_BITS];
            if (q > 32767)
                round_sat = 16'h7fff;
            else if (q < -32768)
                round_sat = 16'h8000;
            else
                round_sat = q[ELEM_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/skinning_matrix_palette.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | bone_id, parent_id, root_flag, local, invbind
// out     | output    | out_valid / out_stall| out_bone_id, world rows, skin rows
// cfg     | input     | cfg_we               | cfg_index, cfg_data
// A non-root word first has its parent's world rows read from the palette, then
// three 4x4 products run on a row of four multiply-accumulate cells, then one step to finish.
// A root word skips the first product.
// Reset is asynchronous, clears control state and sets the bind shape matrix to identity.
// A stalled result holds; the next word is taken once the result has left.
module skinning_matrix_palette #(
    parameter int MAX_BONES = smp_pkg::DEF_MAX_BONES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [smp_pkg::ROW_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [smp_pkg::ID_W-1:0]  bone_id,
    input  logic [smp_pkg::ID_W-1:0]  parent_id,
    input  logic                      root_flag,
    input  logic [smp_pkg::ROW_W-1:0] local_row0,
    input  logic [smp_pkg::ROW_W-1:0] local_row1,
    input  logic [smp_pkg::ROW_W-1:0] local_row2,
    input  logic [smp_pkg::ROW_W-1:0] local_row3,
    input  logic [smp_pkg::ROW_W-1:0] invbind_row0,
    input  logic [smp_pkg::ROW_W-1:0] invbind_row1,
    input  logic [smp_pkg::ROW_W-1:0] invbind_row2,
    input  logic [smp_pkg::ROW_W-1:0] invbind_row3,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [smp_pkg::ID_W-1:0]  out_bone_id,
    output logic [smp_pkg::ROW_W-1:0] world_row0,
    output logic [smp_pkg::ROW_W-1:0] world_row1,
    output logic [smp_pkg::ROW_W-1:0] world_row2,
    output logic [smp_pkg::ROW_W-1:0] world_row3,
    output logic [smp_pkg::ROW_W-1:0] skin_row0,
    output logic [smp_pkg::ROW_W-1:0] skin_row1,
    output logic [smp_pkg::ROW_W-1:0] skin_row2,
    output logic [smp_pkg::ROW_W-1:0] skin_row3
);
    import smp_pkg::*;

    localparam int DEPTH = MAX_BONES * 4;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] k_reg, k_next;
    logic [2:0] rd_cnt_reg;

    logic [ROW_W-1:0] bind_reg [4];
    logic [ROW_W-1:0] loc_reg [4];
    logic [ROW_W-1:0] inv_reg [4];
    logic [ROW_W-1:0] par_reg [4];
    logic [ROW_W-1:0] wld_reg [4];
    logic [ROW_W-1:0] tmp_reg [4];
    logic [ROW_W-1:0] skn_reg [4];
    logic [ID_W-1:0] bone_reg, parent_reg;
    logic root_reg;
    logic valid_reg;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] mem_q;
    logic [AW-1:0] rd_addr;
    logic par_ok, bone_ok;

    logic accept, fin_row, prod_state;
    cell_ctrl_t ctrl;
    logic [ELEM_W-1:0] a_elem;
    logic [ROW_W-1:0] a_row, b_row, b_sel;
    logic [ELEM_W-1:0] res [4];
    logic [ROW_W-1:0] res_row;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || valid_reg;
    assign par_ok = 32'(parent_reg) < MAX_BONES;
    assign bone_ok = 32'(bone_reg) < MAX_BONES;
    assign prod_state = (state_reg == ST_WORLD) || (state_reg == ST_TMP)
                        || (state_reg == ST_SKIN);
    assign fin_row = prod_state && (k_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FETCH;
            ST_FETCH: if (rd_cnt_reg == 3'd5) state_next = root_reg ? ST_TMP : ST_WORLD;
            ST_WORLD: if (fin_row && row_reg == 2'd3) state_next = ST_TMP;
            ST_TMP:   if (fin_row && row_reg == 2'd3) state_next = ST_SKIN;
            ST_SKIN:  if (fin_row && row_reg == 2'd3) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        k_next = prod_state ? k_reg + 2'd1 : 2'd0;
        row_next = row_reg;
        if (!prod_state)
            row_next = 2'd0;
        else if (fin_row)
            row_next = row_reg + 2'd1;
        ctrl.clear = prod_state && (k_reg == 2'd0);
        ctrl.step = prod_state;
    end

    always_comb
    begin
        case (state_reg)
            ST_WORLD: begin a_row = loc_reg[row_reg]; b_sel = par_reg[k_reg]; end
            ST_TMP:   begin a_row = bind_reg[row_reg]; b_sel = inv_reg[k_reg]; end
            default:  begin a_row = tmp_reg[row_reg]; b_sel = wld_reg[k_reg]; end
        endcase
        a_elem = a_row[16*k_reg +: 16];
        b_row = b_sel;
    end

    genvar c;
    generate
        for (c = 0; c < 4; c++)
        begin : g_cell
            smp_mac_cell u_cell (
                .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                .a_elem(a_elem), .b_elem(b_row[16*c +: 16]), .result(res[c])
            );
        end
    endgenerate

    assign res_row = {res[3], res[2], res[1], res[0]};

    logic fin_d_reg;
    state_t fin_st_reg;
    logic [1:0] fin_row_reg;

    always_comb
    begin
        rd_addr = AW'({parent_reg, 2'b00}) + AW'(rd_cnt_reg[1:0]);
    end

    // The world rows go to the palette, one at the start of each skin-product row, while the skin product runs.
    always_ff @(posedge clk)
    begin
        mem_q <= mem[rd_addr];
        if (state_reg == ST_SKIN && k_reg == 2'd0 && bone_ok)
            mem[AW'({bone_reg, 2'b00}) + AW'(row_reg)] <= wld_reg[row_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bone_reg <= bone_id;
            parent_reg <= parent_id;
            root_reg <= root_flag;
            loc_reg <= '{local_row0, local_row1, local_row2, local_row3};
            inv_reg <= '{invbind_row0, invbind_row1, invbind_row2, invbind_row3};
            if (root_flag)
                wld_reg <= '{local_row0, local_row1, local_row2, local_row3};
        end
        if (state_reg == ST_FETCH && rd_cnt_reg >= 3'd1 && rd_cnt_reg <= 3'd4)
            par_reg[2'(rd_cnt_reg - 3'd1)] <= par_ok ? mem_q : '0;
        if (fin_d_reg)
        begin
            case (fin_st_reg)
                ST_WORLD: wld_reg[fin_row_reg] <= res_row;
                ST_TMP:   tmp_reg[fin_row_reg] <= res_row;
                default:  skn_reg[fin_row_reg] <= res_row;
            endcase
        end
        fin_st_reg <= state_reg;
        fin_row_reg <= row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg <= '0;
            k_reg <= '0;
            rd_cnt_reg <= '0;
            valid_reg <= 1'b0;
            fin_d_reg <= 1'b0;
            bind_reg <= '{BIND_RST0, BIND_RST1, BIND_RST2, BIND_RST3};
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
            k_reg <= k_next;
            fin_d_reg <= fin_row;
            rd_cnt_reg <= (state_reg == ST_FETCH) ? rd_cnt_reg + 3'd1 : 3'd0;
            if (state_reg == ST_OUT)
                valid_reg <= 1'b1;
            else if (valid_reg && !out_stall)
                valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BIND0: bind_reg[0] <= cfg_data;
                    REG_BIND1: bind_reg[1] <= cfg_data;
                    REG_BIND2: bind_reg[2] <= cfg_data;
                    REG_BIND3: bind_reg[3] <= cfg_data;
                    default:   bind_reg[0] <= bind_reg[0];
                endcase
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_bone_id = bone_reg;
    assign world_row0 = wld_reg[0];
    assign world_row1 = wld_reg[1];
    assign world_row2 = wld_reg[2];
    assign world_row3 = wld_reg[3];
    assign skin_row0 = skn_reg[0];
    assign skin_row1 = skn_reg[1];
    assign skin_row2 = skn_reg[2];
    assign skin_row3 = skn_reg[3];
endmodule

// ===== rtl/smp_mac_cell.sv =====
module smp_mac_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  smp_pkg::cell_ctrl_t       ctrl,
    input  logic [smp_pkg::ELEM_W-1:0] a_elem,
    input  logic [smp_pkg::ELEM_W-1:0] b_elem,
    output logic [smp_pkg::ELEM_W-1:0] result
);
    import smp_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [2*ELEM_W-1:0] prod;

    assign prod = $signed(a_elem) * $signed(b_elem);

    always_comb
    begin
        if (ctrl.clear)
            acc_next = ACC_W'(prod);
        else if (ctrl.step)
            acc_next = acc_reg + ACC_W'(prod);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign result = round_sat(acc_reg);
endmodule

// ===== rtl/smp_checker.sv =====
module smp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [5:0] out_bone_id,
    input logic [5:0] bone_id,
    input logic root_flag
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_bone_id))
        else $error("Stalled result word changed.");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("Input taken while a result word waits.");

    a_id_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !root_flag |=> ##55 out_valid
            && out_bone_id == $past(bone_id, 56))
        else $error("Result word carries the wrong bone index.");

    a_id_match_root: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && root_flag |=> ##39 out_valid
            && out_bone_id == $past(bone_id, 40))
        else $error("Root result word carries the wrong bone index.");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("Result word appeared too early.");
endmodule

bind skinning_matrix_palette smp_checker u_smp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bone_id(out_bone_id), .bone_id(bone_id), .root_flag(root_flag)
);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smp_pkg::*;

    localparam int BONES = DEF_MAX_BONES;
    localparam int CYCLE_LIMIT = 1000000;

    typedef logic [ROW_W-1:0] row4_t [4];

    typedef struct {
        logic [ID_W-1:0] bone;
        row4_t world;
        row4_t skin;
    } bone_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [ROW_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [ID_W-1:0] bone_id;
    logic [ID_W-1:0] parent_id;
    logic root_flag;
    logic [ROW_W-1:0] local_row0, local_row1, local_row2, local_row3;
    logic [ROW_W-1:0] invbind_row0, invbind_row1, invbind_row2, invbind_row3;
    logic out_valid;
    logic out_stall;
    logic [ID_W-1:0] out_bone_id;
    logic [ROW_W-1:0] world_row0, world_row1, world_row2, world_row3;
    logic [ROW_W-1:0] skin_row0, skin_row1, skin_row2, skin_row3;

    row4_t bind_shape;
    row4_t palette [BONES];
    bit palette_written [BONES];
    int written_ids [$];
    bone_result_t pending_results [$];
    int mismatches;
    int cycles;
    int max_gap;
    bit hold_request;

    skinning_matrix_palette dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("skinning_matrix_palette: mismatch");
            $finish;
        end
    end

    function automatic logic [ELEM_W-1:0] round_clip(longint acc);
        longint q;
        q = (acc + 2048) >>> FRAC_BITS;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[ELEM_W-1:0];
    endfunction

    function automatic row4_t mat_product(row4_t a, row4_t b);
        row4_t p;
        longint acc;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += longint'($signed(a[i][16*k +: 16])) *
                           longint'($signed(b[k][16*j +: 16]));
                p[i][16*j +: 16] = round_clip(acc);
            end
        end
        return p;
    endfunction

    task automatic predict_bone(logic [ID_W-1:0] bone, logic [ID_W-1:0] parent, logic root,
                                row4_t lcl, row4_t inv);
        bone_result_t r;
        row4_t pw;
        pw = '{default: '0};
        if (root)
            r.world = lcl;
        else
        begin
            if (parent < BONES)
                pw = palette[parent];
            r.world = mat_product(lcl, pw);
        end
        r.bone = bone;
        r.skin = mat_product(mat_product(bind_shape, inv), r.world);
        if (bone < BONES)
        begin
            palette[bone] = r.world;
            if (!palette_written[bone])
                written_ids.push_back(int'(bone));
            palette_written[bone] = 1'b1;
        end
        pending_results.push_back(r);
    endtask

    task automatic report(string what, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
        $display("%0t %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        bone_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected word", ROW_W'(out_bone_id), '0);
            else
            begin
                e = pending_results.pop_front();
                if (out_bone_id !== e.bone)
                    report("out_bone_id", ROW_W'(out_bone_id), ROW_W'(e.bone));
                if (world_row0 !== e.world[0]) report("world_row0", world_row0, e.world[0]);
                if (world_row1 !== e.world[1]) report("world_row1", world_row1, e.world[1]);
                if (world_row2 !== e.world[2]) report("world_row2", world_row2, e.world[2]);
                if (world_row3 !== e.world[3]) report("world_row3", world_row3, e.world[3]);
                if (skin_row0 !== e.skin[0]) report("skin_row0", skin_row0, e.skin[0]);
                if (skin_row1 !== e.skin[1]) report("skin_row1", skin_row1, e.skin[1]);
                if (skin_row2 !== e.skin[2]) report("skin_row2", skin_row2, e.skin[2]);
                if (skin_row3 !== e.skin[3]) report("skin_row3", skin_row3, e.skin[3]);
            end
        end
    end

    // Result side: a fresh stall length for every word, or one long hold when asked.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(0, max_gap);
            if (hold_request)
            begin
                n = 400;
                hold_request = 1'b0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_bone(logic [ID_W-1:0] bone, logic [ID_W-1:0] parent, logic root,
                             row4_t lcl, row4_t inv);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        bone_id <= bone;
        parent_id <= parent;
        root_flag <= root;
        local_row0 <= lcl[0];
        local_row1 <= lcl[1];
        local_row2 <= lcl[2];
        local_row3 <= lcl[3];
        invbind_row0 <= inv[0];
        invbind_row1 <= inv[1];
        invbind_row2 <= inv[2];
        invbind_row3 <= inv[3];
        do @(posedge clk); while (in_stall);
        predict_bone(bone, parent, root, lcl, inv);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_bind(logic [1:0] idx, logic [ROW_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        bind_shape[idx] = value;
    endtask

    function automatic row4_t fill_rows(logic [ELEM_W-1:0] v);
        row4_t m;
        for (int r = 0; r < 4; r++)
            m[r] = {4{v}};
        return m;
    endfunction

    function automatic row4_t identity_rows();
        return '{BIND_RST0, BIND_RST1, BIND_RST2, BIND_RST3};
    endfunction

    function automatic row4_t random_rows();
        row4_t m;
        int mode;
        mode = $urandom_range(0, 3);
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                case (mode)
                    0: m[r][16*c +: 16] = 16'($urandom);
                    1: m[r][16*c +: 16] = (r == c ? 16'h1000 : 16'h0000)
                                          + 16'($signed($urandom_range(0, 1600)) - 800);
                    2: m[r][16*c +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    default: m[r][16*c +: 16] = 16'($signed($urandom_range(0, 12000)) - 6000);
                endcase
            end
        end
        return m;
    endfunction

    task automatic send_random_bone();
        logic [ID_W-1:0] bone;
        logic [ID_W-1:0] parent;
        logic root;
        bone = ID_W'($urandom_range(0, BONES - 1));
        root = (written_ids.size() == 0) || ($urandom_range(0, 7) == 0);
        if (root)
            parent = ID_W'($urandom);
        else
            parent = ID_W'(written_ids[$urandom_range(0, written_ids.size() - 1)]);
        send_bone(bone, parent, root, random_rows(), random_rows());
    endtask

    task automatic test_directed();
        row4_t id;
        row4_t tie;
        id = identity_rows();
        tie = fill_rows(16'h0000);
        tie[0] = 64'h0000_0000_0000_0001;
        tie[1] = 64'h0000_0000_0000_ffff;
        send_bone(6'd0, 6'd0, 1'b1, id, id);
        send_bone(6'd63, 6'd0, 1'b0, fill_rows(16'h7fff), fill_rows(16'h7fff));
        send_bone(6'd1, 6'd63, 1'b0, fill_rows(16'h8000), fill_rows(16'h8000));
        send_bone(6'd2, 6'd1, 1'b0, fill_rows(16'hffff), id);
        send_bone(6'd2, 6'd2, 1'b0, id, fill_rows(16'h0001));
        send_bone(6'd3, 6'd0, 1'b1, fill_rows(16'h0800), id);
        send_bone(6'd4, 6'd3, 1'b0, tie, id);
        send_bone(6'd5, 6'd0, 1'b1, fill_rows(16'h0000), fill_rows(16'h0000));
        send_bone(6'd6, 6'd5, 1'b0, id, id);
        send_bone(6'd42, 6'd21, 1'b1, fill_rows(16'h5555), fill_rows(16'haaaa));
        send_bone(6'd21, 6'd42, 1'b0, fill_rows(16'haaaa), fill_rows(16'h5555));
        send_bone(6'd63, 6'd63, 1'b0, fill_rows(16'h7fff), fill_rows(16'h8000));
    endtask

    task automatic test_random(int count);
        repeat (count) send_random_bone();
    endtask

    task automatic test_bind_settings();
        row4_t setting;
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: setting = fill_rows(16'h7fff);
                1: setting = fill_rows(16'h8000);
                2: setting = fill_rows(16'h0000);
                default: setting = random_rows();
            endcase
            for (int r = 0; r < 4; r++)
                write_bind(r[1:0], setting[r]);
            test_random(100);
        end
        for (int r = 0; r < 4; r++)
            write_bind(r[1:0], 64'hffff_ffff_ffff_ffff);
        test_random(50);
        setting = identity_rows();
        write_bind(REG_BIND0, setting[0]);
        write_bind(REG_BIND1, setting[1]);
        write_bind(REG_BIND2, setting[2]);
        write_bind(REG_BIND3, setting[3]);
    endtask

    task automatic test_back_pressure();
        drain();
        hold_request = 1'b1;
        test_random(20);
        drain();
        test_random(20);
    endtask

    task automatic test_no_idling();
        max_gap = 0;
        test_random(300);
        max_gap = 10;
    endtask

    initial
    begin
        mismatches = 0;
        cycles = 0;
        max_gap = 10;
        hold_request = 1'b0;
        bind_shape = identity_rows();
        palette = '{default: '{default: '0}};
        palette_written = '{default: 1'b0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        bone_id = '0;
        parent_id = '0;
        root_flag = 1'b0;
        {local_row0, local_row1, local_row2, local_row3} = '0;
        {invbind_row0, invbind_row1, invbind_row2, invbind_row3} = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        test_bind_settings();
        test_back_pressure();
        test_no_idling();
        test_random(200);
        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("skinning_matrix_palette: match");
        else
            $display("skinning_matrix_palette: mismatch");
        $finish;
    end

endmodule
